// File: sv/mwm_pkg.sv
package mwm_pkg;

    localparam int XW  = 24;   // sample width, Q3.20
    localparam int XDW = 28;   // driven sample width
    localparam int QW  = 28;   // divider quotient bits
    localparam int RW  = 64;   // divider remainder width
    localparam int DVW = 37;   // divisor width
    localparam int CW  = 16;   // drive / mix register width

    localparam logic [1:0] MODE_SOFT  = 2'd0;
    localparam logic [1:0] MODE_HARD  = 2'd1;
    localparam logic [1:0] MODE_FOLD  = 2'd2;
    localparam logic [1:0] MODE_CRUSH = 2'd3;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_DRIVE = 2'd1;
    localparam logic [1:0] REG_MIX   = 2'd2;

    localparam logic [CW-1:0] MIX_BYPASS_MAX   = 16'd65;
    localparam logic [CW-1:0] DRIVE_BYPASS_MAX = 16'd6;

    // per-word side data that rides along the divider
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic                 neg;
        logic                 bypass;
    } side_t;

    // 2^(k/64) in unsigned Q1.15
    function automatic logic [15:0] exp2_frac(input logic [5:0] k);
        logic [15:0] r;
        case (k)
            6'd0:  r = 16'd32768; 6'd1:  r = 16'd33125; 6'd2:  r = 16'd33486;
            6'd3:  r = 16'd33850; 6'd4:  r = 16'd34219; 6'd5:  r = 16'd34591;
            6'd6:  r = 16'd34968; 6'd7:  r = 16'd35349; 6'd8:  r = 16'd35734;
            6'd9:  r = 16'd36123; 6'd10: r = 16'd36516; 6'd11: r = 16'd36914;
            6'd12: r = 16'd37316; 6'd13: r = 16'd37722; 6'd14: r = 16'd38133;
            6'd15: r = 16'd38548; 6'd16: r = 16'd38968; 6'd17: r = 16'd39392;
            6'd18: r = 16'd39821; 6'd19: r = 16'd40255; 6'd20: r = 16'd40693;
            6'd21: r = 16'd41136; 6'd22: r = 16'd41584; 6'd23: r = 16'd42037;
            6'd24: r = 16'd42495; 6'd25: r = 16'd42958; 6'd26: r = 16'd43425;
            6'd27: r = 16'd43898; 6'd28: r = 16'd44376; 6'd29: r = 16'd44859;
            6'd30: r = 16'd45348; 6'd31: r = 16'd45842; 6'd32: r = 16'd46341;
            6'd33: r = 16'd46846; 6'd34: r = 16'd47356; 6'd35: r = 16'd47871;
            6'd36: r = 16'd48393; 6'd37: r = 16'd48920; 6'd38: r = 16'd49452;
            6'd39: r = 16'd49991; 6'd40: r = 16'd50535; 6'd41: r = 16'd51085;
            6'd42: r = 16'd51642; 6'd43: r = 16'd52204; 6'd44: r = 16'd52773;
            6'd45: r = 16'd53347; 6'd46: r = 16'd53928; 6'd47: r = 16'd54515;
            6'd48: r = 16'd55109; 6'd49: r = 16'd55709; 6'd50: r = 16'd56316;
            6'd51: r = 16'd56929; 6'd52: r = 16'd57549; 6'd53: r = 16'd58176;
            6'd54: r = 16'd58809; 6'd55: r = 16'd59449; 6'd56: r = 16'd60097;
            6'd57: r = 16'd60751; 6'd58: r = 16'd61413; 6'd59: r = 16'd62081;
            6'd60: r = 16'd62757; 6'd61: r = 16'd63441; 6'd62: r = 16'd64132;
            6'd63: r = 16'd64830;
            default: r = 16'd32768;
        endcase
        return r;
    endfunction

endpackage

// File: sv/mwm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module mwm_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_vld,
    input  logic [mwm_pkg::RW-1:0]          in_rem,
    input  logic [mwm_pkg::DVW-1:0]         in_den,
    input  mwm_pkg::side_t                  in_side,
    output logic                            out_vld,
    output logic [mwm_pkg::QW-1:0]          out_quo,
    output mwm_pkg::side_t                  out_side
);

    localparam int QW = mwm_pkg::QW;

    logic                      vld_reg  [1:QW];
    logic [mwm_pkg::RW-1:0]    rem_reg  [1:QW];
    logic [mwm_pkg::DVW-1:0]   den_reg  [1:QW];
    logic [QW-1:0]             quo_reg  [1:QW];
    mwm_pkg::side_t            side_reg [1:QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        localparam int B = QW - 1 - i;
        logic                    vld_cur;
        logic [mwm_pkg::RW-1:0]  rem_cur;
        logic [mwm_pkg::DVW-1:0] den_cur;
        logic [QW-1:0]           quo_cur;
        mwm_pkg::side_t          side_cur;
        logic [mwm_pkg::RW-1:0]  sub;
        logic                    take;

        if (i == 0)
        begin : g_head
            assign vld_cur  = in_vld;
            assign rem_cur  = in_rem;
            assign den_cur  = in_den;
            assign quo_cur  = '0;
            assign side_cur = in_side;
        end
        else
        begin : g_body
            assign vld_cur  = vld_reg[i];
            assign rem_cur  = rem_reg[i];
            assign den_cur  = den_reg[i];
            assign quo_cur  = quo_reg[i];
            assign side_cur = side_reg[i];
        end

        assign sub  = mwm_pkg::RW'(den_cur) << B;
        assign take = rem_cur >= sub;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i+1] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i+1]  <= take ? rem_cur - sub : rem_cur;
                den_reg[i+1]  <= den_cur;
                quo_reg[i+1]  <= quo_cur | (take ? (QW'(1) << B) : '0);
                side_reg[i+1] <= side_cur;
            end
        end
    end

    assign out_vld  = vld_reg[QW];
    assign out_quo  = quo_reg[QW];
    assign out_side = side_reg[QW];

endmodule

// File: sv/multimode_waveshaper_mix.sv
// multimode_waveshaper_mix: drive gain, one of four shapers, dry/wet blend.
// Input channel: sample_in (Q3.20) with in_valid / in_stall.
// Output channel: sample_out (Q3.20, saturated) with out_valid / out_stall.
// One output word for every input word, in order.
// Config channel: cfg_valid / cfg_ready with cfg_index, cfg_data;
//   index 0 shape_mode, 1 drive_amount, 2 wet_mix, index 3 ignored.
//   cfg_ready is always high. Write only while the pipe is empty.
// Pipeline: 6 front stages for gain, squaring and operand setup,
//   28 divider stages at one quotient bit each, then the mix multiply
//   and the round/saturate output register.
// Throughput: one word per cycle when not stalled; all stages are fully pipelined.
// Stall: the whole pipe holds while the output word waits, so in_stall
//   goes high exactly when out_valid is high and out_stall is high.
// Reset: mode, drive and mix clear to zero (soft clip, no drive, no mix, i.e.
//   bypass), the pipe empties. Bypass words (tiny mix or drive) go
//   through the same pipe, so order and latency are unchanged.
module multimode_waveshaper_mix
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [23:0]         sample_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [23:0]         sample_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [15:0]                cfg_data
);

    localparam int XW  = mwm_pkg::XW;
    localparam int XDW = mwm_pkg::XDW;
    localparam int RW  = mwm_pkg::RW;
    localparam int DVW = mwm_pkg::DVW;

    // ---------------- config registers
    logic [1:0]  mode_reg;
    logic [15:0] drive_reg;
    logic [15:0] mix_reg;
    logic [23:0] step_reg;      // crush step count, Q.15

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= mwm_pkg::MODE_SOFT;
            drive_reg <= '0;
            mix_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mwm_pkg::REG_MODE:  mode_reg  <= cfg_data[1:0];
                mwm_pkg::REG_DRIVE: drive_reg <= cfg_data;
                mwm_pkg::REG_MIX:   mix_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // crush exponent 8 - 6.5*D in Q.17; integer part 1..7 once drive is live
    logic [20:0] crush_exp;
    assign crush_exp = 21'(8 << 17) - 21'(drive_reg) * 21'd13;

    always_ff @(posedge clk)
    begin
        step_reg <= 24'(mwm_pkg::exp2_frac(crush_exp[16:11])) << crush_exp[19:17];
    end

    logic [19:0] gain;          // Q4.16
    assign gain = 20'd65536 + 20'(drive_reg) * 20'd9;

    logic adv;
    logic out_valid_reg;
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // ---------------- stage 1: x * gain
    logic                   s1_vld_reg;
    logic signed [XW-1:0]   s1_x_reg;
    logic                   s1_byp_reg;
    logic signed [44:0]     s1_prod_reg;

    // ---------------- stage 2: round to xd
    logic                   s2_vld_reg;
    logic signed [XW-1:0]   s2_x_reg;
    logic                   s2_byp_reg;
    logic signed [XDW-1:0]  s2_xd_reg;

    // ---------------- stage 3: squares and crush product, hard/fold result
    logic                   s3_vld_reg;
    logic signed [XW-1:0]   s3_x_reg;
    logic                   s3_byp_reg;
    logic signed [XDW-1:0]  s3_xd_reg;
    logic [55:0]            s3_sq_reg;
    logic signed [52:0]     s3_m_reg;
    logic signed [XDW-1:0]  s3_ys_reg;

    // ---------------- stage 4: x2 and n
    logic                   s4_vld_reg;
    logic signed [XW-1:0]   s4_x_reg;
    logic                   s4_byp_reg;
    logic signed [XDW-1:0]  s4_xd_reg;
    logic [33:0]            s4_x2_reg;
    logic [17:0]            s4_nmag_reg;
    logic                   s4_nneg_reg;
    logic signed [XDW-1:0]  s4_ys_reg;

    // ---------------- stage 5: soft numerator partial products
    logic                   s5_vld_reg;
    logic signed [XW-1:0]   s5_x_reg;
    logic                   s5_byp_reg;
    logic                   s5_xneg_reg;
    logic [43:0]            s5_pplo_reg;
    logic [43:0]            s5_pphi_reg;
    logic [DVW-1:0]         s5_den_reg;
    logic [17:0]            s5_nmag_reg;
    logic                   s5_nneg_reg;
    logic signed [XDW-1:0]  s5_ys_reg;

    // ---------------- stage 6: divider operands
    logic                   s6_vld_reg;
    logic [RW-1:0]          s6_rem_reg;
    logic [DVW-1:0]         s6_den_reg;
    mwm_pkg::side_t         s6_side_reg;

    // stage 2 rounding
    logic [44:0] p_mag;
    logic [28:0] p_q;
    assign p_mag = s1_prod_reg[44] ? 45'(-s1_prod_reg) : 45'(s1_prod_reg);
    assign p_q   = 29'((p_mag + 45'd32768) >> 16);

    // stage 3 hard clip and fold
    logic signed [XDW-1:0] hard_y;
    logic [21:0]           fold_v;
    logic signed [22:0]    fold_t;
    logic [22:0]           fold_a;
    logic signed [XDW-1:0] fold_y;
    always_comb
    begin
        if (s2_xd_reg > XDW'(1 << 20))
            hard_y = XDW'(1 << 20);
        else if (s2_xd_reg < -XDW'(1 << 20))
            hard_y = -XDW'(1 << 20);
        else
            hard_y = s2_xd_reg;
        fold_v = 22'(s2_xd_reg[21:0] + 22'(1 << 20));
        fold_t = $signed({1'b0, fold_v}) - 23'sd2097152;
        fold_a = fold_t[22] ? 23'(-fold_t) : 23'(fold_t);
        fold_y = XDW'($signed({1'b0, fold_a})) - XDW'(1 << 20);
    end

    // stage 4 rounding
    logic [52:0] m_mag;
    assign m_mag = s3_m_reg[52] ? 53'(-s3_m_reg) : 53'(s3_m_reg);

    // stage 5 soft terms
    logic [26:0] xd_mag;
    logic [33:0] soft_t;
    assign xd_mag = s4_xd_reg[XDW-1] ? 27'(-s4_xd_reg) : 27'(s4_xd_reg);
    assign soft_t = 34'(27 << 20) + s4_x2_reg;

    // stage 6 operand select
    logic [RW-1:0]  num_sel;
    logic [DVW-1:0] den_sel;
    logic           neg_sel;
    logic [XDW-1:0] ys_mag;
    assign ys_mag = s5_ys_reg[XDW-1] ? XDW'(-s5_ys_reg) : XDW'(s5_ys_reg);
    always_comb
    begin
        case (mode_reg)
            mwm_pkg::MODE_SOFT:
            begin
                num_sel = (RW'(s5_pphi_reg) << 17) + RW'(s5_pplo_reg);
                den_sel = s5_den_reg;
                neg_sel = s5_xneg_reg;
            end
            mwm_pkg::MODE_CRUSH:
            begin
                num_sel = RW'(s5_nmag_reg) << 35;
                den_sel = DVW'(step_reg);
                neg_sel = s5_nneg_reg;
            end
            default:
            begin
                // hard clip and fold: divide by one, no rounding term
                num_sel = RW'(ys_mag);
                den_sel = DVW'(1);
                neg_sel = s5_ys_reg[XDW-1];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg    <= sample_in;
            s1_byp_reg  <= (mix_reg <= mwm_pkg::MIX_BYPASS_MAX) ||
                           (drive_reg <= mwm_pkg::DRIVE_BYPASS_MAX);
            s1_prod_reg <= 45'(sample_in) * 45'($signed({1'b0, gain}));

            s2_x_reg    <= s1_x_reg;
            s2_byp_reg  <= s1_byp_reg;
            s2_xd_reg   <= s1_prod_reg[44] ? -XDW'(p_q) : XDW'(p_q);

            s3_x_reg    <= s2_x_reg;
            s3_byp_reg  <= s2_byp_reg;
            s3_xd_reg   <= s2_xd_reg;
            s3_sq_reg   <= 56'(56'(s2_xd_reg) * 56'(s2_xd_reg));
            s3_m_reg    <= 53'(s2_xd_reg) * 53'($signed({1'b0, step_reg}));
            s3_ys_reg   <= (mode_reg == mwm_pkg::MODE_HARD) ? hard_y : fold_y;

            s4_x_reg    <= s3_x_reg;
            s4_byp_reg  <= s3_byp_reg;
            s4_xd_reg   <= s3_xd_reg;
            s4_x2_reg   <= 34'((s3_sq_reg + 56'(1 << 19)) >> 20);
            s4_nmag_reg <= 18'((m_mag + (53'd1 << 34)) >> 35);
            s4_nneg_reg <= s3_m_reg[52];
            s4_ys_reg   <= s3_ys_reg;

            s5_x_reg    <= s4_x_reg;
            s5_byp_reg  <= s4_byp_reg;
            s5_xneg_reg <= s4_xd_reg[XDW-1];
            s5_pplo_reg <= 44'(xd_mag) * 44'(soft_t[16:0]);
            s5_pphi_reg <= 44'(xd_mag) * 44'(soft_t[33:17]);
            s5_den_reg  <= DVW'(27 << 20) + (DVW'(s4_x2_reg) << 3) + DVW'(s4_x2_reg);
            s5_nmag_reg <= s4_nmag_reg;
            s5_nneg_reg <= s4_nneg_reg;
            s5_ys_reg   <= s4_ys_reg;

            s6_rem_reg         <= num_sel + RW'(den_sel >> 1);
            s6_den_reg         <= den_sel;
            s6_side_reg.x      <= s5_x_reg;
            s6_side_reg.neg    <= neg_sel;
            s6_side_reg.bypass <= s5_byp_reg;
        end
    end

    // ---------------- divider
    logic                   dv_vld;
    logic [mwm_pkg::QW-1:0] dv_quo;
    mwm_pkg::side_t         dv_side;

    mwm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (s6_vld_reg),
        .in_rem   (s6_rem_reg),
        .in_den   (s6_den_reg),
        .in_side  (s6_side_reg),
        .out_vld  (dv_vld),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    // ---------------- mix products
    logic                   m1_vld_reg;
    logic signed [XW-1:0]   m1_x_reg;
    logic                   m1_byp_reg;
    logic signed [XDW:0]    m1_y_reg;
    logic signed [41:0]     m1_dry_reg;
    logic signed [45:0]     m1_wet_reg;

    logic signed [XDW:0] y_val;
    logic [16:0]         dry_w;
    assign y_val = dv_side.neg ? -(XDW+1)'(dv_quo) : (XDW+1)'(dv_quo);
    assign dry_w = 17'd65536 - 17'(mix_reg);

    // ---------------- round and saturate
    logic signed [46:0] mix_sum;
    logic [46:0]        mix_mag;
    logic [30:0]        mix_q;
    logic signed [31:0] mix_r;
    logic signed [XW-1:0] mix_out;
    always_comb
    begin
        mix_sum = 47'(m1_dry_reg) + 47'(m1_wet_reg);
        mix_mag = mix_sum[46] ? 47'(-mix_sum) : 47'(mix_sum);
        mix_q   = 31'((mix_mag + 47'd32768) >> 16);
        mix_r   = mix_sum[46] ? -32'($signed({1'b0, mix_q})) : 32'($signed({1'b0, mix_q}));
        if (m1_byp_reg)
            mix_out = m1_x_reg;
        else if (mix_r > 32'sd8388607)
            mix_out = 24'sh7FFFFF;
        else if (mix_r < -32'sd8388608)
            mix_out = 24'sh800000;
        else
            mix_out = XW'(mix_r);
    end

    logic signed [XW-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_vld_reg    <= dv_vld;
            out_valid_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_x_reg     <= dv_side.x;
            m1_byp_reg   <= dv_side.bypass;
            m1_y_reg     <= y_val;
            m1_dry_reg   <= 42'(dv_side.x) * 42'($signed({1'b0, dry_w}));
            m1_wet_reg   <= 46'(y_val) * 46'($signed({1'b0, mix_reg}));
            out_data_reg <= mix_out;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

    // ---------------- checks
    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without output backpressure");

    a_hard_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m1_vld_reg && !m1_byp_reg && mode_reg == mwm_pkg::MODE_HARD) |->
        (m1_y_reg <= (XDW+1)'(1 << 20) && m1_y_reg >= -(XDW+1)'(1 << 20)))
        else $error("hard clip result out of range");

    a_bypass_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (m1_vld_reg && m1_byp_reg && adv) |=> (sample_out == $past(m1_x_reg)))
        else $error("bypass word altered");

endmodule

// File: verif/tb_multimode_waveshaper_mix.sv
`timescale 1ns / 1ps

module tb_multimode_waveshaper_mix;

    localparam int LATENCY     = 36;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] REG_UNUSED = 2'd3;   // index with no register behind it

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [23:0] sample_in;
    logic               out_valid;
    logic               out_stall;
    logic signed [23:0] sample_out;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    multimode_waveshaper_mix i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Shadow copy of the shaper settings, updated as each register write lands.
    logic [1:0]  cur_mode;
    logic [15:0] cur_drive;
    logic [15:0] cur_mix;

    logic signed [23:0] pending_samples[$];   // words waiting to be driven
    logic signed [23:0] expected_out[$];      // predicted output words
    int unsigned        sent_count;
    int unsigned        recv_count;
    int unsigned        mismatch_count;
    int unsigned        cycle_count;
    bit                 timed_out;
    int unsigned        phase_count;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Division rounded to nearest, ties away from zero; den > 0.
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint exp2_q15(input int k);
        int unsigned exp2_rom[64] = '{
            32768, 33125, 33486, 33850, 34219, 34591, 34968, 35349,
            35734, 36123, 36516, 36914, 37316, 37722, 38133, 38548,
            38968, 39392, 39821, 40255, 40693, 41136, 41584, 42037,
            42495, 42958, 43425, 43898, 44376, 44859, 45348, 45842,
            46341, 46846, 47356, 47871, 48393, 48920, 49452, 49991,
            50535, 51085, 51642, 52204, 52773, 53347, 53928, 54515,
            55109, 55709, 56316, 56929, 57549, 58176, 58809, 59449,
            60097, 60751, 61413, 62081, 62757, 63441, 64132, 64830};
        return longint'(exp2_rom[k]);
    endfunction

    // Shaped and blended sample for the current settings.
    function automatic logic signed [23:0] waveshape(input logic signed [23:0] s);
        longint x;
        longint xd;
        longint y;
        longint x2;
        longint v;
        longint step;
        longint n;
        longint r;
        longint one;
        int unsigned e;
        one = 64'sd1 <<< 20;
        x   = s;
        if (cur_mix <= mwm_pkg::MIX_BYPASS_MAX || cur_drive <= mwm_pkg::DRIVE_BYPASS_MAX)
            return s;
        xd = round_div(x * (65536 + 9 * longint'(cur_drive)), 65536);
        case (cur_mode)
            mwm_pkg::MODE_SOFT:
            begin
                x2 = round_div(xd * xd, one);
                y  = round_div(xd * (27 * one + x2), 27 * one + 9 * x2);
            end
            mwm_pkg::MODE_HARD:
            begin
                y = (xd > one) ? one : ((xd < -one) ? -one : xd);
            end
            mwm_pkg::MODE_FOLD:
            begin
                v = (xd + one) & (4 * one - 1);
                y = v - 2 * one;
                if (y < 0)
                    y = -y;
                y = y - one;
            end
            default:
            begin
                e    = (8 << 17) - 13 * int'(cur_drive);
                step = exp2_q15(int'((e >> 11) & 63)) <<< ((e >> 17) & 15);
                n    = round_div(xd * step, 64'sd1 <<< 35);
                y    = round_div(n * (64'sd1 <<< 35), step);
            end
        endcase
        r = round_div(x * (65536 - longint'(cur_mix)) + y * longint'(cur_mix), 65536);
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        return r[23:0];
    endfunction

    // Input acceptance, taken at the rising edge.
    bit in_taken;
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            expected_out.push_back(waveshape(sample_in));
            sent_count++;
            in_taken <= 1'b1;
        end
        else
        begin
            in_taken <= 1'b0;
        end
    end

    // Input driver: random gap before each word, word held while stalled.
    int unsigned in_gap;
    bit          in_next;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            in_next = in_valid && !in_taken;
            if (in_taken)
                in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
            if (!in_next)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (pending_samples.size() > 0)
                begin
                    sample_in <= pending_samples.pop_front();
                    in_next = 1'b1;
                end
            end
            in_valid <= in_next;
        end
    end

    // Output side stall pattern: per word, a random number of stalled cycles.
    int unsigned out_hold;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_valid)
                    out_hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            end
        end
    end

    // Monitor: compare each accepted output word with the oldest prediction.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            recv_count <= recv_count + 1;
            if (expected_out.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected output word %0d", sample_out);
            end
            else
            begin
                logic signed [23:0] want;
                want = expected_out.pop_front();
                if (sample_out !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: sample_out exp %0d got %0d", want, sample_out);
                end
            end
        end
    end

    // Cycle limit watchdog.
    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            mwm_pkg::REG_MODE:  cur_mode  = val[1:0];
            mwm_pkg::REG_DRIVE: cur_drive = val;
            mwm_pkg::REG_MIX:   cur_mix   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drain the pipe, then let the latency pass before the next write.
    task automatic drain_pipe;
        while (pending_samples.size() > 0 || in_valid || expected_out.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [1:0] mode, input logic [15:0] drv,
                                  input logic [15:0] mx);
        drain_pipe();
        write_reg(mwm_pkg::REG_MODE, 16'(mode));
        write_reg(mwm_pkg::REG_DRIVE, drv);
        write_reg(mwm_pkg::REG_MIX, mx);
        phase_count++;
    endtask

    // Random sample: mostly near the shaper knees, some full scale extremes.
    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return $signed(24'($urandom_range(0, 4194304))) - 24'sd2097152;
            2: return $signed(24'($urandom_range(0, 1048576))) - 24'sd524288;
            default: return ($urandom_range(0, 1)) ? 24'sh7FFFFF : 24'sh800000;
        endcase
    endfunction

    logic [15:0] drv_pick;
    logic [15:0] mix_pick;

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample_in = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = mwm_pkg::REG_MODE;
        cfg_data  = '0;
        cur_mode  = mwm_pkg::MODE_SOFT;
        cur_drive = '0;
        cur_mix   = '0;
        in_gap    = 0;
        out_hold  = 0;
        sent_count = 0;
        recv_count = 0;
        mismatch_count = 0;
        cycle_count = 0;
        timed_out = 1'b0;
        phase_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: bypass, words pass through untouched.
        pending_samples.push_back(24'sh7FFFFF);
        pending_samples.push_back(24'sh800000);
        pending_samples.push_back(24'sh000000);
        pending_samples.push_back(24'sh155555);

        // Directed: every mode at full drive and mix with extreme samples.
        for (int m = 0; m < 4; m++)
        begin
            apply_settings(m[1:0], 16'hFFFF, 16'hFFFF);
            pending_samples.push_back(24'sh7FFFFF);
            pending_samples.push_back(24'sh800000);
            pending_samples.push_back(24'sh100000);
            pending_samples.push_back(-24'sh0C0000);
            pending_samples.push_back(24'sh000001);
        end
        // Bypass edges: mix at 65/66, drive at 6/7; also the unused index is ignored.
        apply_settings(mwm_pkg::MODE_FOLD, 16'd40000, 16'd65);
        pending_samples.push_back(24'sh3ABCDE);
        apply_settings(mwm_pkg::MODE_FOLD, 16'd40000, 16'd66);
        pending_samples.push_back(24'sh3ABCDE);
        apply_settings(mwm_pkg::MODE_CRUSH, 16'd6, 16'd50000);
        pending_samples.push_back(-24'sh2ABCDE);
        apply_settings(mwm_pkg::MODE_CRUSH, 16'd7, 16'd50000);
        pending_samples.push_back(-24'sh2ABCDE);
        drain_pipe();
        write_reg(REG_UNUSED, 16'hFFFF);
        pending_samples.push_back(24'sh123456);

        // Random phases: new settings every ~100 words, extremes mixed in.
        for (int p = 0; p < 20; p++)
        begin
            case ($urandom_range(0, 4))
                0: drv_pick = 16'hFFFF;
                1: drv_pick = 16'($urandom_range(0, 8));
                default: drv_pick = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: mix_pick = 16'hFFFF;
                1: mix_pick = 16'($urandom_range(60, 70));
                default: mix_pick = 16'($urandom);
            endcase
            apply_settings(2'($urandom_range(0, 3)), drv_pick, mix_pick);
            for (int i = 0; i < 100; i++)
                pending_samples.push_back(rand_sample());
        end

        drain_pipe();
        $display("Covered %0d words over %0d register settings, all four shapes.",
                 sent_count, phase_count);
        $display("Bypass thresholds, saturation and random stalls both sides included.");
        if (mismatch_count == 0 && recv_count == sent_count)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
